>>> src/button_press_classifier_macros.svh
// assertion macros shared by the button press classifier rtl
// no dependencies; taken in by `include where assertions are written
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication under asynchronous active-low reset
`define BPC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define BPC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bpc_pkg.sv
// package for the button press classifier: widths, codes, reset values, structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

	localparam int NOW_W  = 32;
	localparam int LIM_W  = 16;
	localparam int CNT_W  = 8;
	localparam int HOLD_W = 2;
	localparam int ACT_W  = 2;
	localparam int MODE_W = 2;
	localparam int IDX_W  = 3;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_NOISE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_SHORT_LIM = 3'd1;
	localparam logic [IDX_W-1:0] REG_LONG_LIM  = 3'd2;
	localparam logic [IDX_W-1:0] REG_CHAIN_GAP = 3'd3;
	localparam logic [IDX_W-1:0] REG_SETTLE    = 3'd4;
	localparam logic [IDX_W-1:0] REG_CALIB_CNT = 3'd5;

	// configuration reset values
	localparam logic [LIM_W-1:0] NOISE_RST     = 16'd25;
	localparam logic [LIM_W-1:0] SHORT_LIM_RST = 16'd1000;
	localparam logic [LIM_W-1:0] LONG_LIM_RST  = 16'd5000;
	localparam logic [LIM_W-1:0] CHAIN_GAP_RST = 16'd400;
	localparam logic [LIM_W-1:0] SETTLE_RST    = 16'd500;
	localparam logic [CNT_W-1:0] CALIB_CNT_RST = 8'd10;

	// hold indication codes
	localparam logic [HOLD_W-1:0] HOLD_NONE  = 2'd0;
	localparam logic [HOLD_W-1:0] HOLD_SHORT = 2'd1;
	localparam logic [HOLD_W-1:0] HOLD_LONG  = 2'd2;
	localparam logic [HOLD_W-1:0] HOLD_OVER  = 2'd3;

	// press action codes
	localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CALIB   = 2'd2;

	// radio mode codes
	localparam logic [MODE_W-1:0] MODE_FAST32 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FAST64 = 2'd2;

	localparam logic [CNT_W-1:0] CHAIN_MAX = 8'd255;

	typedef struct packed {
		logic [LIM_W-1:0] noise;
		logic [LIM_W-1:0] short_lim;
		logic [LIM_W-1:0] long_lim;
		logic [LIM_W-1:0] chain_gap;
		logic [LIM_W-1:0] settle;
		logic [CNT_W-1:0] calib_cnt;
	} bpc_cfg_t;

	typedef struct packed {
		logic [HOLD_W-1:0] hold;
		logic              power_off;
		logic [ACT_W-1:0]  action;
		logic [MODE_W-1:0] mode;
	} bpc_result_t;

endpackage

`default_nettype wire

>>> src/bpc_core.sv
// press classifier state and per-sample decision logic
// depends on bpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpc_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       step,
	input  wire                       level,
	input  wire [bpc_pkg::NOW_W-1:0]  now,
	input  wire bpc_pkg::bpc_cfg_t    cfg,
	output bpc_pkg::bpc_result_t      res
);
	import bpc_pkg::*;

	logic              pressed_q;
	logic [NOW_W-1:0]  start_q;
	logic              pend_q;
	logic [NOW_W-1:0]  issued_q;
	logic [CNT_W-1:0]  chain_q;
	logic [MODE_W-1:0] mode_q;

	logic [NOW_W-1:0]  start_eff;
	logic [NOW_W-1:0]  diff;
	logic [NOW_W-1:0]  gap_d;
	logic [NOW_W-1:0]  settle_d;
	logic [NOW_W-1:0]  noise_x;
	logic [NOW_W-1:0]  short_x;
	logic [NOW_W-1:0]  long_x;
	logic              rel;
	logic              above_noise;
	logic              short_rel;
	logic              long_rel;
	logic              fire;
	logic              do_calib;
	logic [HOLD_W-1:0] hold;
	logic              pend_n;
	logic              pend_nn;
	logic [NOW_W-1:0]  issued_n;
	logic [NOW_W-1:0]  start_n;
	logic [CNT_W-1:0]  chain_n;
	logic [MODE_W-1:0] mode_n;
	logic [MODE_W-1:0] mode_adv;
	logic [ACT_W-1:0]  action;

	// mode rotation, unused code falls back to fast32
	always_comb begin
		unique case (mode_q)
			MODE_FAST32: mode_adv = MODE_BLE;
			MODE_BLE:    mode_adv = MODE_FAST64;
			default:     mode_adv = MODE_FAST32;
		endcase
	end

	// durations and classification
	always_comb begin
		noise_x   = {{(NOW_W-LIM_W){1'b0}}, cfg.noise};
		short_x   = {{(NOW_W-LIM_W){1'b0}}, cfg.short_lim};
		long_x    = {{(NOW_W-LIM_W){1'b0}}, cfg.long_lim};
		start_eff = pressed_q ? start_q : now;
		diff      = now - start_eff;
		gap_d     = now - issued_q;

		// hold indication, higher range wins on overlap
		hold = HOLD_NONE;
		if (level) begin
			if (diff > noise_x && diff < short_x) hold = HOLD_SHORT;
			if (diff > short_x && diff < long_x)  hold = HOLD_LONG;
			if (diff > long_x)                    hold = HOLD_OVER;
		end

		// release sorting
		rel         = !level && pressed_q;
		above_noise = diff > noise_x;
		short_rel   = rel && above_noise && (diff < short_x);
		long_rel    = rel && above_noise && !(diff < short_x) && (diff < long_x);

		// chain count, restarts when the gap is too wide, saturates at the top
		chain_n = chain_q;
		if (short_rel) begin
			if (gap_d < {{(NOW_W-LIM_W){1'b0}}, cfg.chain_gap}) begin
				if (chain_q != CHAIN_MAX) chain_n = chain_q + 1'b1;
			end else begin
				chain_n = '0;
			end
		end

		pend_n   = pend_q | short_rel;
		issued_n = short_rel ? now : issued_q;
		start_n  = level ? start_eff : start_q;

		// settle check runs after the release on the same sample
		settle_d = now - issued_n;
		fire     = pend_n && (settle_d > {{(NOW_W-LIM_W){1'b0}}, cfg.settle});
		do_calib = chain_n >= cfg.calib_cnt;
		pend_nn  = pend_n && !fire;

		action = ACT_NONE;
		mode_n = mode_q;
		if (fire) begin
			if (do_calib) begin
				action = ACT_CALIB;
			end else begin
				action = ACT_ADVANCE;
				mode_n = mode_adv;
			end
		end

		res.hold      = hold;
		res.power_off = long_rel;
		res.action    = action;
		res.mode      = mode_n;
	end

	// state update on each processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			start_q   <= '0;
			pend_q    <= 1'b0;
			issued_q  <= '0;
			chain_q   <= '0;
			mode_q    <= MODE_FAST32;
		end else if (step) begin
			pressed_q <= level;
			start_q   <= start_n;
			pend_q    <= pend_nn;
			issued_q  <= issued_n;
			chain_q   <= chain_n;
			mode_q    <= mode_n;
		end
	end

endmodule

`default_nettype wire

>>> src/button_press_classifier.sv
// Button press classifier. One sample (button level and millisecond time) is taken per
// clock while in_stall is low; each gives one result: hold indication, power-off request,
// press action and radio mode. A sample lands in the input register, is classified
// against the press state in one pass and the outcome sits in the result register;
// throughput is one sample per cycle while out_stall is low. in_stall rises only when
// both the input and result registers are full. Configuration is written through
// cfg_valid/cfg_ready (always ready) and should only change while idle.
// depends on bpc_pkg, bpc_core and button_press_classifier_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "button_press_classifier_macros.svh"

module button_press_classifier (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration writes
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [bpc_pkg::IDX_W-1:0]   cfg_index,
	input  wire [bpc_pkg::LIM_W-1:0]   cfg_data,
	// sample channel
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        button_level,
	input  wire [bpc_pkg::NOW_W-1:0]   now_ms,
	// result channel
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [bpc_pkg::HOLD_W-1:0] hold_indication,
	output logic                       power_off_request,
	output logic [bpc_pkg::ACT_W-1:0]  press_action,
	output logic [bpc_pkg::MODE_W-1:0] link_mode
);
	import bpc_pkg::*;

	bpc_cfg_t         cfg_q;
	logic             valid_s1;
	logic             level_s1;
	logic [NOW_W-1:0] now_s1;
	logic             valid_s2;
	bpc_result_t      res_s2;
	bpc_result_t      res;
	logic             advance;

	assign cfg_ready = 1'b1;

	// configuration registers, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise     <= NOISE_RST;
			cfg_q.short_lim <= SHORT_LIM_RST;
			cfg_q.long_lim  <= LONG_LIM_RST;
			cfg_q.chain_gap <= CHAIN_GAP_RST;
			cfg_q.settle    <= SETTLE_RST;
			cfg_q.calib_cnt <= CALIB_CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NOISE:     cfg_q.noise     <= cfg_data;
				REG_SHORT_LIM: cfg_q.short_lim <= cfg_data;
				REG_LONG_LIM:  cfg_q.long_lim  <= cfg_data;
				REG_CHAIN_GAP: cfg_q.chain_gap <= cfg_data;
				REG_SETTLE:    cfg_q.settle    <= cfg_data;
				REG_CALIB_CNT: cfg_q.calib_cnt <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= button_level;
			now_s1   <= now_ms;
		end
	end

	// classification and press state
	bpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (level_s1),
		.now    (now_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid         = valid_s2;
	assign hold_indication   = res_s2.hold;
	assign power_off_request = res_s2.power_off;
	assign press_action      = res_s2.action;
	assign link_mode         = res_s2.mode;

	// checks
	`BPC_ASSERT_NOW(a_stall_needs_item, clk, arst_n, in_stall, valid_s1, "stall with empty input register")
	`BPC_ASSERT_NEXT(a_step_gives_result, clk, arst_n, advance, valid_s2, "processed sample left no result")
	`BPC_ASSERT_NOW(a_release_no_hold, clk, arst_n, out_valid && power_off_request, hold_indication == HOLD_NONE, "power off with hold indication")

endmodule

`default_nettype wire
